FILE: sv/idd_pkg.sv
`default_nettype none

package idd_pkg;

  // Field widths of one request.
  localparam int unsigned ENERGY_W = 16;
  localparam int unsigned TIME_W   = 32;

  // Time that must be exceeded between two reported impacts, in milliseconds.
  localparam logic [TIME_W-1:0] LOCKOUT_MS = 32'd500;

  // Drop threshold after reset: 2.0 g in unsigned Q8.8.
  localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 16'd512;

  // Commands from the top level to the window scanner.
  typedef struct packed {
    logic start;  // store the sample and walk the window
    logic clear;  // forget every stored sample
  } scan_req_t;

  // Scanner sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_TAIL = 3'b100
  } scan_state_t;

endpackage

`default_nettype wire

FILE: sv/idd_ram.sv
`default_nettype none

module idd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/idd_scan.sv
`default_nettype none

// Stores one sample in the ring window, then walks every entry through a
// single comparator to find the window peak. Entries never written since the
// last clear have their valid bit low and count as zero.
module idd_scan #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire idd_pkg::scan_req_t            req,
  input  wire logic [idd_pkg::ENERGY_W-1:0]  energy,
  output logic                               done,
  output logic      [idd_pkg::ENERGY_W-1:0]  peak
);

  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_DEPTH - 1);

  idd_pkg::scan_state_t state;
  logic [IDX_W-1:0]          slot;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          rd_idx;
  logic                      rd_pend;
  logic [WINDOW_DEPTH-1:0]   valid;
  logic [idd_pkg::ENERGY_W-1:0] rdata;
  logic                      wr_en;

  assign wr_en = (state == idd_pkg::ST_IDLE) && req.start;

  idd_ram #(
    .WIDTH (idd_pkg::ENERGY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (energy),
    .raddr (idx),
    .rdata (rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= idd_pkg::ST_IDLE;
      slot    <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
      valid   <= '0;
      done    <= 1'b0;
    end else begin
      done <= (state == idd_pkg::ST_TAIL);
      unique case (state)
        idd_pkg::ST_IDLE: begin
          rd_pend <= 1'b0;
          if (req.clear) begin
            valid <= '0;
          end else if (req.start) begin
            valid[slot] <= 1'b1;
            slot        <= (slot == LAST) ? '0 : slot + 1'b1;
            idx         <= '0;
            state       <= idd_pkg::ST_SCAN;
          end
        end
        idd_pkg::ST_SCAN: begin
          rd_pend <= 1'b1;
          if (idx == LAST) begin
            state <= idd_pkg::ST_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        idd_pkg::ST_TAIL: begin
          rd_pend <= 1'b0;
          state   <= idd_pkg::ST_IDLE;
        end
        default: begin
          state <= idd_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Shared comparator: one window entry per cycle, the cycle after its read.
  always_ff @(posedge clk) begin
    rd_idx <= idx;
    if (wr_en) begin
      peak <= '0;
    end else if (rd_pend && valid[rd_idx] && (rdata > peak)) begin
      peak <= rdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/impact_drop_detector_top.sv
`default_nettype none

// Channel   Direction  Signals                        Contents
// s_        in         s_tvalid s_tready s_tdata      energy_level [15:0], time_ms [47:16]
//                      s_tuser                        enabled [0]
// m_        out        m_tvalid m_tready m_tdata      impact [0], bits [7:1] zero
// cfg_      in         cfg_we cfg_wdata               drop_threshold [15:0]
//
// An enabled request moves through these steps from acceptance until its
// result is in the output register: the sample is written at the accepting
// edge, then one read per window entry through the single comparator,
// a final compare, the decision and the move into the output register.
// A disabled request clears the window at once and its result moves to the
// output register when it is free. s_tready stays low from acceptance until
// the result has moved into the output register. rst is synchronous and
// active high; it empties the window, zeroes the write slot and the last
// impact time, and restores the threshold to 2.0 g. A stalled output holds
// its result while the next request is already accepted and worked on.
module impact_drop_detector_top #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Incoming motion samples.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // energy_level [15:0], time_ms [47:16]
  input  wire logic [0:0]  s_tuser,   // enabled [0]
  // Impact results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // impact [0], zero padding [7:1]
  // Threshold register.
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic                          busy;
  logic                          res_ready;
  logic                          res_bit;
  logic [idd_pkg::ENERGY_W-1:0]  threshold;
  logic [idd_pkg::ENERGY_W-1:0]  cur;
  logic [idd_pkg::TIME_W-1:0]    now;
  logic [idd_pkg::TIME_W-1:0]    last_impact;
  logic                          accept;
  logic                          scan_done;
  logic [idd_pkg::ENERGY_W-1:0]  peak;
  logic [idd_pkg::ENERGY_W-1:0]  drop;
  logic [idd_pkg::TIME_W-1:0]    elapsed;
  logic                          hit;
  logic                          out_free;
  idd_pkg::scan_req_t            req;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // A disabled sample clears the window; an enabled one is stored and scanned.
  assign req.start = accept && s_tuser[0];
  assign req.clear = accept && !s_tuser[0];

  idd_scan #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .energy (s_tdata[15:0]),
    .done   (scan_done),
    .peak   (peak)
  );

  // The current sample is itself in the window, so the drop cannot underflow.
  assign drop    = peak - cur;
  assign elapsed = now - last_impact;
  assign hit     = (drop > threshold) && (elapsed > idd_pkg::LOCKOUT_MS);

  // Sample payload captured at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= s_tdata[15:0];
      now <= s_tdata[47:16];
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= idd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Request tracking, impact decision and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      res_ready   <= 1'b0;
      res_bit     <= 1'b0;
      last_impact <= '0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        if (!s_tuser[0]) begin
          res_ready <= 1'b1;
          res_bit   <= 1'b0;
        end
      end

      if (scan_done) begin
        res_ready <= 1'b1;
        res_bit   <= hit;
        if (hit) begin
          last_impact <= now;
        end
      end

      // Move a finished result into the output register once it is free.
      if (res_ready && out_free) begin
        m_tvalid  <= 1'b1;
        m_tdata   <= {7'd0, res_bit};
        res_ready <= 1'b0;
        busy      <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
